// ===== hdl/mi3_pkg.sv =====
// Shared widths, types and helpers for the 3x3 adjugate matrix inverse.
// No dependencies; used by mi3_divider and matrix_inverse_3x3.
`timescale 1ns / 1ps

package mi3_pkg;

  localparam int unsigned EW        = 32;  // element width, Q16.16
  localparam int unsigned PW        = 64;  // element by element product
  localparam int unsigned CW        = 65;  // signed cofactor
  localparam int unsigned XW        = 66;  // element by cofactor half product
  localparam int unsigned DW        = 98;  // signed determinant
  localparam int unsigned MW        = 97;  // determinant magnitude
  localparam int unsigned CMW       = 64;  // cofactor magnitude
  localparam int unsigned QW        = 33;  // quotient bits, one divider stage each
  localparam int unsigned RW        = 98;  // divider remainder
  localparam int unsigned ORDER_W   = 2;
  localparam int unsigned MAX_ORDER = 3;

  localparam logic [ORDER_W-1:0] ORDER_ONE = ORDER_W'(1);
  localparam logic [ORDER_W-1:0] ORDER_TWO = ORDER_W'(2);
  localparam logic [ORDER_W-1:0] ORDER_MAX = ORDER_W'(MAX_ORDER);

  localparam logic [QW-1:0] POS_LIMIT = QW'(33'h07FFF_FFFF);
  localparam logic [QW-1:0] NEG_LIMIT = QW'(33'h080000000);
  localparam logic [EW-1:0] POS_SAT   = 32'h7FFF_FFFF;
  localparam logic [EW-1:0] NEG_SAT   = 32'h8000_0000;

  typedef logic signed [EW-1:0] elem_t;
  typedef logic signed [CW-1:0] cof_t;

  // Per-beat information that travels beside the divider.
  typedef struct packed {
    logic [8:0] neg;   // quotient is negative
    logic [8:0] big;   // quotient is known to exceed 33 bits
    logic [8:0] act;   // element lies inside the active order
    logic       sing;  // determinant is zero
  } side_t;

  // Order zero acts as order one, anything above the maximum as the maximum.
  function automatic logic [ORDER_W-1:0] eff_order(input logic [ORDER_W-1:0] o);
    logic [ORDER_W-1:0] r;
    r = o;
    if (o == '0) r = ORDER_ONE;
    if (o > ORDER_MAX) r = ORDER_MAX;
    return r;
  endfunction

endpackage

// ===== hdl/mi3_divider.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on mi3_pkg for its widths.
`timescale 1ns / 1ps

module mi3_divider (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [mi3_pkg::CMW-1:0] num_i,
  input  logic [mi3_pkg::MW-1:0]  den_i,
  output logic [mi3_pkg::QW-1:0]  quo_o
);

  localparam int unsigned QW = mi3_pkg::QW;
  localparam int unsigned RW = mi3_pkg::RW;
  localparam int unsigned MW = mi3_pkg::MW;

  logic [RW-1:0] rem_q [QW];
  logic [MW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];

  // The numerator is num_i * 2^32: the first stage sees num_i whole, the later
  // stages bring in zero bits. Callers must keep num_i < 2 * den_i (no check).
  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [RW-1:0] shf;
    logic [MW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic          ge;

    if (k == 0) begin : g_first
      assign shf    = RW'(num_i);
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign shf    = {rem_q[k-1][RW-2:0], 1'b0};
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign ge = shf >= RW'(den_in);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? shf - RW'(den_in) : shf;
        den_q[k] <= den_in;
        quo_q[k] <= {quo_in[QW-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

// ===== hdl/matrix_inverse_3x3.sv =====
// Inverse of a square Q16.16 matrix of order one to three: a fully pipelined
// block that takes one matrix beat per clock cycle and gives one result beat
// per cycle while the output is not stalled. Each matrix passes through 40
// register stages. Six stages form the cofactors and the determinant
// (input capture, element products, cofactor differences, determinant
// partial products, determinant sum and sign handling), then nine 33-stage
// restoring dividers work side by side, one quotient bit per stage, and a
// last register saturates and shows the result.
// The whole pipeline advances together and holds while a shown result is
// stalled. The order register may only be written while the block is empty.
// Depends on mi3_pkg and mi3_divider.
`timescale 1ns / 1ps

module matrix_inverse_3x3 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mi3_pkg::ORDER_W-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [mi3_pkg::EW-1:0] m00_i,
  input  logic signed [mi3_pkg::EW-1:0] m01_i,
  input  logic signed [mi3_pkg::EW-1:0] m02_i,
  input  logic signed [mi3_pkg::EW-1:0] m10_i,
  input  logic signed [mi3_pkg::EW-1:0] m11_i,
  input  logic signed [mi3_pkg::EW-1:0] m12_i,
  input  logic signed [mi3_pkg::EW-1:0] m20_i,
  input  logic signed [mi3_pkg::EW-1:0] m21_i,
  input  logic signed [mi3_pkg::EW-1:0] m22_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [mi3_pkg::EW-1:0] inv00_o,
  output logic signed [mi3_pkg::EW-1:0] inv01_o,
  output logic signed [mi3_pkg::EW-1:0] inv02_o,
  output logic signed [mi3_pkg::EW-1:0] inv10_o,
  output logic signed [mi3_pkg::EW-1:0] inv11_o,
  output logic signed [mi3_pkg::EW-1:0] inv12_o,
  output logic signed [mi3_pkg::EW-1:0] inv20_o,
  output logic signed [mi3_pkg::EW-1:0] inv21_o,
  output logic signed [mi3_pkg::EW-1:0] inv22_o,
  output logic                          singular_o,
  output logic                          overflow_o
);

  localparam int unsigned EW  = mi3_pkg::EW;
  localparam int unsigned PW  = mi3_pkg::PW;
  localparam int unsigned CW  = mi3_pkg::CW;
  localparam int unsigned XW  = mi3_pkg::XW;
  localparam int unsigned DW  = mi3_pkg::DW;
  localparam int unsigned MW  = mi3_pkg::MW;
  localparam int unsigned CMW = mi3_pkg::CMW;
  localparam int unsigned QW  = mi3_pkg::QW;
  localparam int unsigned OW  = mi3_pkg::ORDER_W;

  // Configuration register.
  logic [OW-1:0] order_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= mi3_pkg::ORDER_MAX;
    end else if (cfg_we_i) begin
      order_q <= cfg_data_i;
    end
  end

  // The pipeline moves as one whenever the output register is free.
  logic adv;
  logic out_valid_q;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // Valid bits for the six arithmetic stages and the divider stages.
  logic [5:0]    vld_q;
  logic [QW-1:0] dvld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      dvld_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[4:0], in_valid_i};
      dvld_q      <= {dvld_q[QW-2:0], vld_q[5]};
      out_valid_q <= dvld_q[QW-1];
    end
  end

  // Stage 1: capture the matrix and the effective order.
  mi3_pkg::elem_t e1_q [3][3];
  logic [OW-1:0]  n1_q, n2_q, n3_q, n4_q, n5_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e1_q[0][0] <= m00_i;
      e1_q[0][1] <= m01_i;
      e1_q[0][2] <= m02_i;
      e1_q[1][0] <= m10_i;
      e1_q[1][1] <= m11_i;
      e1_q[1][2] <= m12_i;
      e1_q[2][0] <= m20_i;
      e1_q[2][1] <= m21_i;
      e1_q[2][2] <= m22_i;
      n1_q       <= mi3_pkg::eff_order(order_q);
      n2_q       <= n1_q;
      n3_q       <= n2_q;
      n4_q       <= n3_q;
      n5_q       <= n4_q;
    end
  end

  // Stage 2: the two products of every order-three cofactor.
  mi3_pkg::elem_t      e2_q  [3][3];
  logic signed [PW-1:0] pa2_q [3][3];
  logic signed [PW-1:0] pb2_q [3][3];

  for (genvar r = 0; r < 3; r++) begin : g_prod_r
    for (genvar c = 0; c < 3; c++) begin : g_prod_c
      localparam int R1 = (r + 1) % 3;
      localparam int R2 = (r + 2) % 3;
      localparam int C1 = (c + 1) % 3;
      localparam int C2 = (c + 2) % 3;
      always_ff @(posedge clk_i) begin
        if (adv) begin
          e2_q[r][c]  <= e1_q[r][c];
          pa2_q[r][c] <= PW'(e1_q[R1][C1]) * PW'(e1_q[R2][C2]);
          pb2_q[r][c] <= PW'(e1_q[R1][C2]) * PW'(e1_q[R2][C1]);
        end
      end
    end
  end

  // Stage 3: cofactors chosen by order. The order-three cofactor at row two,
  // column two is the order-two determinant, so it serves both.
  mi3_pkg::cof_t  cf_full [3][3];
  mi3_pkg::cof_t  cf_sel  [3][3];
  mi3_pkg::cof_t  cof3_q  [3][3];
  mi3_pkg::cof_t  dsm3_q;
  mi3_pkg::elem_t row3_q  [3];

  for (genvar r = 0; r < 3; r++) begin : g_cf_r
    for (genvar c = 0; c < 3; c++) begin : g_cf_c
      assign cf_full[r][c] = CW'(pa2_q[r][c]) - CW'(pb2_q[r][c]);
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        cf_sel[r][c] = '0;
      end
    end
    if (n2_q == mi3_pkg::ORDER_ONE) begin
      cf_sel[0][0] = CW'(1);
    end else if (n2_q == mi3_pkg::ORDER_TWO) begin
      cf_sel[0][0] = CW'(e2_q[1][1]);
      cf_sel[0][1] = -CW'(e2_q[1][0]);
      cf_sel[1][0] = -CW'(e2_q[0][1]);
      cf_sel[1][1] = CW'(e2_q[0][0]);
    end else begin
      cf_sel = cf_full;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cof3_q <= cf_sel;
      dsm3_q <= (n2_q == mi3_pkg::ORDER_ONE) ? CW'(e2_q[0][0]) : cf_full[2][2];
      row3_q <= e2_q[0];
    end
  end

  // Stage 4: first-row elements times their cofactors, each cofactor cut into
  // an unsigned low word and a signed high part.
  mi3_pkg::cof_t        cof4_q [3][3];
  mi3_pkg::cof_t        dsm4_q;
  logic signed [XW-1:0] pl4_q  [3];
  logic signed [XW-1:0] ph4_q  [3];

  for (genvar c = 0; c < 3; c++) begin : g_dp
    always_ff @(posedge clk_i) begin
      if (adv) begin
        pl4_q[c] <= XW'(row3_q[c]) * XW'(signed'({1'b0, cof3_q[0][c][EW-1:0]}));
        ph4_q[c] <= XW'(row3_q[c]) * XW'(signed'(cof3_q[0][c][CW-1:EW]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cof4_q <= cof3_q;
      dsm4_q <= dsm3_q;
    end
  end

  // Stage 5: determinant.
  logic signed [DW-1:0] det_sum;
  logic signed [DW-1:0] det5_q;
  mi3_pkg::cof_t        cof5_q [3][3];

  always_comb begin
    det_sum = '0;
    for (int c = 0; c < 3; c++) begin
      det_sum = det_sum + (DW'(ph4_q[c]) <<< EW) + DW'(pl4_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      det5_q <= (n4_q == mi3_pkg::ORDER_MAX) ? det_sum : DW'(dsm4_q);
      cof5_q <= cof4_q;
    end
  end

  // Stage 6: magnitudes and signs for the dividers. A quotient of 2^33 or more
  // is caught here, which keeps the dividers at 33 steps.
  logic              det_neg;
  logic [MW-1:0]     det_mag;
  logic [CMW-1:0]    mc6_q [3][3];
  logic [MW-1:0]     md6_q;
  mi3_pkg::side_t    side6;
  mi3_pkg::side_t    side6_q;

  assign det_neg = det5_q[DW-1];
  assign det_mag = MW'(det_neg ? -det5_q : det5_q);

  for (genvar r = 0; r < 3; r++) begin : g_mag_r
    for (genvar c = 0; c < 3; c++) begin : g_mag_c
      logic           cneg;
      logic [CMW-1:0] cmag;
      assign cneg = cof5_q[c][r][CW-1];
      assign cmag = CMW'(cneg ? -cof5_q[c][r] : cof5_q[c][r]);
      assign side6.neg[r*3+c] = cneg ^ det_neg;
      assign side6.big[r*3+c] = (MW+1)'(cmag) >= {det_mag, 1'b0};
      assign side6.act[r*3+c] = (OW'(r) < n5_q) && (OW'(c) < n5_q);
      always_ff @(posedge clk_i) begin
        if (adv) begin
          mc6_q[r][c] <= cmag;
        end
      end
    end
  end

  assign side6.sing = det5_q == '0;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      md6_q   <= det_mag;
      side6_q <= side6;
    end
  end

  // Divider stages: nine dividers share one determinant magnitude.
  logic [QW-1:0]  quo [9];
  mi3_pkg::side_t side_q [QW];

  for (genvar k = 0; k < 9; k++) begin : g_div
    mi3_divider u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (mc6_q[k/3][k%3]),
      .den_i (md6_q),
      .quo_o (quo[k])
    );
  end

  for (genvar k = 0; k < QW; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (adv) begin
        side_q[k] <= (k == 0) ? side6_q : side_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  // Output stage: sign, saturation and masking.
  mi3_pkg::side_t side_o;
  logic [EW-1:0]  res   [9];
  logic [8:0]     sat;
  logic [EW-1:0]  res_q [9];
  logic           sing_q;
  logic           ovf_q;

  assign side_o = side_q[QW-1];

  for (genvar k = 0; k < 9; k++) begin : g_res
    logic [EW-1:0] sval;
    assign sat[k] = side_o.big[k] ||
                    (side_o.neg[k] ? quo[k] > mi3_pkg::NEG_LIMIT
                                   : quo[k] > mi3_pkg::POS_LIMIT);
    assign sval   = side_o.neg[k] ? mi3_pkg::NEG_SAT : mi3_pkg::POS_SAT;
    assign res[k] = (!side_o.act[k] || side_o.sing) ? '0 :
                    sat[k] ? sval :
                    side_o.neg[k] ? -quo[k][EW-1:0] : quo[k][EW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q  <= res;
      sing_q <= side_o.sing;
      ovf_q  <= !side_o.sing && |(sat & side_o.act);
    end
  end

  assign out_valid_o = out_valid_q;
  assign inv00_o     = res_q[0];
  assign inv01_o     = res_q[1];
  assign inv02_o     = res_q[2];
  assign inv10_o     = res_q[3];
  assign inv11_o     = res_q[4];
  assign inv12_o     = res_q[5];
  assign inv20_o     = res_q[6];
  assign inv21_o     = res_q[7];
  assign inv22_o     = res_q[8];
  assign singular_o  = sing_q;
  assign overflow_o  = ovf_q;

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for matrix_inverse_3x3: directed and random matrices
// of every order, checked beat by beat against an in-bench adjugate predictor.
// Depends on mi3_pkg and the matrix_inverse_3x3 RTL only.
`timescale 1ns / 1ps

module tb;

  // Settling wait after the last result: the block's pipeline plus some margin.
  localparam int unsigned DRAIN_CYCLES = 48;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam logic [mi3_pkg::EW-1:0] ONE_Q16 = 32'h0001_0000;

  // One expected result beat: nine inverse elements and the two flags.
  typedef struct packed {
    logic [8:0][mi3_pkg::EW-1:0] inv;
    logic                        sing;
    logic                        ovf;
  } inverse_beat_t;

  typedef mi3_pkg::elem_t matrix_t [9];

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [mi3_pkg::ORDER_W-1:0] cfg_data = mi3_pkg::ORDER_MAX;
  logic in_valid = 1'b0;
  logic in_stall;
  mi3_pkg::elem_t mat_drv [9] = '{default: '0};
  logic out_valid;
  logic out_stall = 1'b0;
  mi3_pkg::elem_t inv_obs [9];
  logic singular, overflow;

  // The predictor's own copy of the order register; reset value is the maximum.
  logic [mi3_pkg::ORDER_W-1:0] order_model = mi3_pkg::ORDER_MAX;
  inverse_beat_t expected_inverses [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  // When set, neither side idles, so the pipeline runs at full rate.
  bit full_rate = 1'b0;

  always #1 clk = ~clk;

  matrix_inverse_3x3 dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .m00_i(mat_drv[0]), .m01_i(mat_drv[1]), .m02_i(mat_drv[2]),
    .m10_i(mat_drv[3]), .m11_i(mat_drv[4]), .m12_i(mat_drv[5]),
    .m20_i(mat_drv[6]), .m21_i(mat_drv[7]), .m22_i(mat_drv[8]),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .inv00_o(inv_obs[0]), .inv01_o(inv_obs[1]), .inv02_o(inv_obs[2]),
    .inv10_o(inv_obs[3]), .inv11_o(inv_obs[4]), .inv12_o(inv_obs[5]),
    .inv20_o(inv_obs[6]), .inv21_o(inv_obs[7]), .inv22_o(inv_obs[8]),
    .singular_o(singular), .overflow_o(overflow)
  );

  // Idle cycles before the next beat on either side; over a quarter of the draws
  // are zero so that back-to-back beats occur outside full-rate stretches too.
  function automatic int unsigned idle_cycles();
    if (full_rate || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  // Raw Q16.16 quotient cof * 2^32 / det, truncated toward zero and saturated.
  function automatic logic [mi3_pkg::EW-1:0] scaled_quotient(
      input logic signed [127:0] cof,
      input logic signed [127:0] det,
      inout logic ovf);
    logic neg;
    logic [127:0] mag_c, mag_d, q, lim;
    neg   = (cof < 0) != (det < 0);
    mag_c = (cof < 0) ? -cof : cof;
    mag_d = (det < 0) ? -det : det;
    q     = (mag_c << 32) / mag_d;
    lim   = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (q > lim) begin
      ovf = 1'b1;
      return neg ? mi3_pkg::NEG_SAT : mi3_pkg::POS_SAT;
    end
    return neg ? -q[mi3_pkg::EW-1:0] : q[mi3_pkg::EW-1:0];
  endfunction

  // Inverse by the transposed cofactor matrix over the determinant, at full width.
  function automatic inverse_beat_t predict_inverse(
      input matrix_t m,
      input logic [mi3_pkg::ORDER_W-1:0] ord);
    logic signed [127:0] e [3][3];
    logic signed [127:0] cof [3][3];
    logic signed [127:0] det;
    inverse_beat_t res;
    int n;
    logic ovf;
    n = (ord == 0) ? 1 : int'(ord);
    ovf = 1'b0;
    res = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        e[r][c] = m[r*3+c];
        cof[r][c] = '0;
      end
    end
    if (n == 1) begin
      cof[0][0] = 1;
      det = e[0][0];
    end else if (n == 2) begin
      cof[0][0] = e[1][1];
      cof[0][1] = -e[1][0];
      cof[1][0] = -e[0][1];
      cof[1][1] = e[0][0];
      det = e[0][0] * e[1][1] - e[0][1] * e[1][0];
    end else begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          cof[r][c] = e[(r+1)%3][(c+1)%3] * e[(r+2)%3][(c+2)%3]
                    - e[(r+1)%3][(c+2)%3] * e[(r+2)%3][(c+1)%3];
        end
      end
      det = e[0][0] * cof[0][0] + e[0][1] * cof[0][1] + e[0][2] * cof[0][2];
    end
    if (det == 0) begin
      res.sing = 1'b1;
      return res;
    end
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        res.inv[r*3+c] = scaled_quotient(cof[c][r], det, ovf);
      end
    end
    res.ovf = ovf;
    return res;
  endfunction

  // Send one matrix beat and wait for it to be accepted. Valid is left high on
  // return so a following beat with no gap goes out on the very next edge.
  task automatic send_matrix(input matrix_t m);
    int unsigned gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    for (int i = 0; i < 9; i++) mat_drv[i] <= m[i];
    expected_inverses.push_back(predict_inverse(m, order_model));
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every expected result has come back, then let
  // the pipeline settle fully.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_inverses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // The order register is only written with the block empty.
  task automatic write_order(input logic [mi3_pkg::ORDER_W-1:0] ord);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= ord;
    @(posedge clk);
    cfg_we <= 1'b0;
    order_model = ord;
  endtask

  function automatic matrix_t diag_matrix(input mi3_pkg::elem_t d0,
                                          input mi3_pkg::elem_t d1,
                                          input mi3_pkg::elem_t d2);
    matrix_t m;
    m = '{default: '0};
    m[0] = d0;
    m[4] = d1;
    m[8] = d2;
    return m;
  endfunction

  // Random matrix: full-range noise, small well-conditioned values, tiny values,
  // extremes, or extremes with a repeated row (zero determinant above order one).
  function automatic matrix_t random_matrix();
    matrix_t m;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) begin
      case (kind)
        0, 1, 2: m[i] = $urandom;
        3, 4, 5: m[i] = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        6:       m[i] = $signed($urandom_range(0, 64)) - 32;
        default: begin
          case ($urandom_range(0, 3))
            0: m[i] = 32'sh7FFF_FFFF;
            1: m[i] = 32'sh8000_0000;
            2: m[i] = '0;
            default: m[i] = $urandom;
          endcase
        end
      endcase
    end
    if (kind == 9) begin
      for (int c = 0; c < 3; c++) m[3+c] = m[c];
    end
    return m;
  endfunction

  // Result side: stall for a random count before each beat, then take it.
  initial begin
    int unsigned hold;
    forever begin
      hold = idle_cycles();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Every accepted result beat is compared with the oldest expectation.
  always @(posedge clk) begin
    inverse_beat_t exp_beat;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_inverses.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("unexpected result beat");
      end else begin
        exp_beat = expected_inverses.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (inv_obs[i] !== exp_beat.inv[i]) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("inv%0d%0d: expected %h, got %h", i / 3, i % 3,
                       exp_beat.inv[i], inv_obs[i]);
          end
        end
        if (singular !== exp_beat.sing || overflow !== exp_beat.ovf) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("flags: expected singular %b overflow %b, got %b %b",
                     exp_beat.sing, exp_beat.ovf, singular, overflow);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("matrix_inverse_3x3 test failed");
      $finish;
    end
  end

  // Directed special cases at the current order: identity, zero matrix,
  // tiny diagonal (saturates positive and negative), most negative and most
  // positive elements, and one general matrix with all nine elements in use.
  task automatic test_directed_cases();
    matrix_t m;
    send_matrix(diag_matrix(ONE_Q16, ONE_Q16, ONE_Q16));
    send_matrix(diag_matrix(0, 0, 0));
    send_matrix(diag_matrix(1, -1, 1));
    send_matrix(diag_matrix(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    send_matrix(diag_matrix(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -32'sh7FFF_FFFF));
    m = '{32'sh0002_0000, -32'sh0001_0000, 32'sh0000_8000,
          32'sh0001_0000, 32'sh0003_0000, -32'sh0002_0000,
          -32'sh0000_4000, 32'sh0001_0000, 32'sh0004_0000};
    send_matrix(m);
  endtask

  // Every order, with order zero standing in for order one.
  task automatic test_every_order();
    logic [mi3_pkg::ORDER_W-1:0] orders [4] = '{mi3_pkg::ORDER_MAX, mi3_pkg::ORDER_TWO,
                                                mi3_pkg::ORDER_ONE, '0};
    foreach (orders[k]) begin
      write_order(orders[k]);
      test_directed_cases();
    end
  endtask

  // Random matrices over several order settings, with full-rate stretches and one
  // mid-setting pause in which the sender waits until every result has returned.
  task automatic test_random_matrices();
    logic [mi3_pkg::ORDER_W-1:0] orders [8] = '{mi3_pkg::ORDER_MAX, mi3_pkg::ORDER_TWO,
                                                mi3_pkg::ORDER_ONE, '0,
                                                mi3_pkg::ORDER_MAX, mi3_pkg::ORDER_TWO,
                                                mi3_pkg::ORDER_MAX, mi3_pkg::ORDER_ONE};
    foreach (orders[k]) begin
      write_order(orders[k]);
      for (int i = 0; i < 118; i++) begin
        if (i % 40 == 0) full_rate = ($urandom_range(0, 2) == 0);
        if (k == 4 && i == 60) drain();
        send_matrix(random_matrix());
      end
      full_rate = 1'b0;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_every_order();
    test_random_matrices();
    drain();
    if (mismatches == 0) begin
      $display("matrix_inverse_3x3 test passed");
    end else begin
      $display("matrix_inverse_3x3 test failed");
    end
    $finish;
  end

endmodule

// ===== matrix_inverse_3x3.f =====
hdl/mi3_pkg.sv
hdl/mi3_divider.sv
hdl/matrix_inverse_3x3.sv
test/tb.sv
